### rtl/dch_pkg.sv
`default_nettype none

package dch_pkg;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_set;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  entry_index;
    logic [23:0] color_count;
    logic        dropped_full;
    logic [8:0]  distinct_colors;
    logic        any_hit;
  } out_word_t;

  // control part of the probe that walks the cell row
  typedef struct packed {
    logic vld;
    cmd_e cmd;
    logic last;
    logic found;
    logic ins;
  } tok_ctl_t;

  localparam int unsigned KeyW = 24;

endpackage

`default_nettype wire

### rtl/dch_cell.sv
`default_nettype none

module dch_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 8,
  parameter int unsigned UW  = 9,
  parameter int unsigned CW  = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [UW-1:0]         used_i,
  input  wire dch_pkg::tok_ctl_t     ctl_i,
  input  wire logic [dch_pkg::KeyW-1:0] key_i,
  input  wire logic [IW-1:0]         slot_i,
  input  wire logic [CW-1:0]         cnt_i,
  output dch_pkg::tok_ctl_t          ctl_o,
  output logic [dch_pkg::KeyW-1:0]   key_o,
  output logic [IW-1:0]              slot_o,
  output logic [CW-1:0]              cnt_o
);

  logic [dch_pkg::KeyW-1:0] key_q;
  logic [CW-1:0]            cnt_q;
  logic [CW-1:0]            cnt_inc;
  logic                     match;
  logic                     ins;

  dch_pkg::tok_ctl_t        ctl_d, ctl_q;
  logic [IW-1:0]            slot_d, slot_q;
  logic [CW-1:0]            cnt_d, cnt_tok_q;
  logic [dch_pkg::KeyW-1:0] key_tok_q;

  assign cnt_inc = (cnt_q == {CW{1'b1}}) ? cnt_q : cnt_q + CW'(1);

  // only slots below the fill count hold colors
  assign match = ctl_i.vld && !ctl_i.found && (UW'(IDX) < used_i) && (key_q == key_i);
  // first free slot takes a missed add
  assign ins   = ctl_i.vld && !ctl_i.found && (ctl_i.cmd == dch_pkg::CMD_ADD) &&
                 (UW'(IDX) == used_i);

  always_comb begin
    ctl_d  = ctl_i;
    slot_d = slot_i;
    cnt_d  = cnt_i;
    if (match) begin
      ctl_d.found = 1'b1;
      slot_d      = IW'(IDX);
      cnt_d       = (ctl_i.cmd == dch_pkg::CMD_ADD) ? cnt_inc : cnt_q;
    end else if (ins) begin
      ctl_d.ins = 1'b1;
      slot_d    = IW'(IDX);
      cnt_d     = CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    cnt_tok_q <= cnt_d;
    key_tok_q <= key_i;
    if (match && (ctl_i.cmd == dch_pkg::CMD_ADD)) begin
      cnt_q <= cnt_inc;
    end else if (ins) begin
      key_q <= key_i;
      cnt_q <= CW'(1);
    end
  end

  assign ctl_o  = ctl_q;
  assign key_o  = key_tok_q;
  assign slot_o = slot_q;
  assign cnt_o  = cnt_tok_q;

endmodule

`default_nettype wire

### rtl/distinct_color_histogram_unit.sv
// Distinct color histogram: palette of 24-bit colors with saturating counts.
// Input channel: in_valid_i / in_stall_o carry one in_word_t per word.
// command add stores or counts the color, query only tests membership and
// folds the hit into a running any-hit flag that clears after a query's last_of_set.
// Output channel: out_valid_o / out_stall_i carry one out_word_t per input.
// The palette lives in a row of TABLE_DEPTH cells; a probe enters cell 0 at
// accept and moves one cell per cycle, so each word passes through the row,
// then a finish register, and lands in the output register. One word is in
// the row at a time; the next word can be taken once the previous result
// has moved to the output register, so a new word is not accepted before
// the previous one has finished its walk through the cell row.
// A finished result may wait in the output register while the next word is
// accepted and walks the row; if out_stall_i holds, the finished probe waits
// in the finish register and in_stall_o stays high.
// Reset empties the palette (fill count zero), clears the any-hit flag and
// drops any word in flight. Stored colors need no clearing.
`default_nettype none

module distinct_color_histogram_unit #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire dch_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dch_pkg::out_word_t      out_word_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = COUNT_BITS;

  dch_pkg::tok_ctl_t        ctl  [TABLE_DEPTH+1];
  logic [dch_pkg::KeyW-1:0] key  [TABLE_DEPTH+1];
  logic [IW-1:0]            slot [TABLE_DEPTH+1];
  logic [CW-1:0]            cnt  [TABLE_DEPTH+1];

  logic [UW-1:0]      used_q, used_d;
  logic               flag_q;
  logic               busy_q;
  logic               accept;
  logic               move;

  dch_pkg::tok_ctl_t  fin_ctl_q;
  logic [IW-1:0]      fin_slot_q;
  logic [CW-1:0]      fin_cnt_q;

  logic               out_valid_q;
  dch_pkg::out_word_t out_q, res;
  logic               any_hit;
  logic [IW+7:0]      slot_ext;
  logic [CW+23:0]     cnt_ext;
  logic [UW+8:0]      used_ext;

  assign accept = in_valid_i && !busy_q;
  assign move   = fin_ctl_q.vld && (!out_valid_q || !out_stall_i);

  assign ctl[0]  = '{vld:   accept,
                     cmd:   dch_pkg::cmd_e'(in_word_i.command),
                     last:  in_word_i.last_of_set,
                     found: 1'b0,
                     ins:   1'b0};
  assign key[0]  = {in_word_i.red, in_word_i.green, in_word_i.blue};
  assign slot[0] = '0;
  assign cnt[0]  = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dch_cell #(
      .IDX(g),
      .IW (IW),
      .UW (UW),
      .CW (CW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .used_i(used_q),
      .ctl_i (ctl[g]),
      .key_i (key[g]),
      .slot_i(slot[g]),
      .cnt_i (cnt[g]),
      .ctl_o (ctl[g+1]),
      .key_o (key[g+1]),
      .slot_o(slot[g+1]),
      .cnt_o (cnt[g+1])
    );
  end

  // result of the probe parked in the finish register
  always_comb begin
    used_d   = used_q + UW'(fin_ctl_q.ins);
    any_hit  = (fin_ctl_q.cmd == dch_pkg::CMD_QUERY) && (flag_q || fin_ctl_q.found);
    slot_ext = {8'b0, fin_slot_q};
    cnt_ext  = {24'b0, fin_cnt_q};
    used_ext = {9'b0, used_d};
    res.hit             = fin_ctl_q.found;
    res.entry_index     = slot_ext[7:0];
    res.color_count     = cnt_ext[23:0];
    res.dropped_full    = (fin_ctl_q.cmd == dch_pkg::CMD_ADD) && !fin_ctl_q.found &&
                          !fin_ctl_q.ins;
    res.distinct_colors = used_ext[8:0];
    res.any_hit         = any_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      used_q      <= '0;
      flag_q      <= 1'b0;
      fin_ctl_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (ctl[TABLE_DEPTH].vld) begin
        fin_ctl_q <= ctl[TABLE_DEPTH];
      end else if (move) begin
        fin_ctl_q.vld <= 1'b0;
      end
      if (move) begin
        used_q <= used_d;
        if (fin_ctl_q.cmd == dch_pkg::CMD_QUERY) begin
          flag_q <= fin_ctl_q.last ? 1'b0 : any_hit;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl[TABLE_DEPTH].vld) begin
      fin_slot_q <= slot[TABLE_DEPTH];
      fin_cnt_q  <= cnt[TABLE_DEPTH];
    end
    if (move) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### tb/dch_checker.sv
`timescale 1ns / 1ps

module dch_checker
  import dch_pkg::*;
#(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned CNT_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  output int        err_cnt_o,
  output int        pending_o,
  output int        hits_o,
  output int        drops_o
);

  // shadow palette; only slots below pal_used are ever read
  bit [23:0]   pal_color [DEPTH];
  bit [63:0]   pal_count [DEPTH];
  int unsigned pal_used;
  bit          set_any;

  out_word_t pending_results[$];
  int        n_checked;

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
    hits_o    = 0;
    drops_o   = 0;
    n_checked = 0;
  end

  // next result of the palette for one word; updates the shadow palette
  function automatic out_word_t palette_step(in_word_t w);
    out_word_t   r;
    bit [23:0]   key;
    bit [63:0]   cmax;
    bit [63:0]   c;
    int unsigned slot;
    bit          found;
    r     = '0;
    key   = {w.red, w.green, w.blue};
    cmax  = (64'd1 << CNT_BITS) - 64'd1;
    c     = '0;
    slot  = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < pal_used; i++) begin
      if (!found && pal_color[i] == key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (w.command == CMD_ADD) begin
      if (found) begin
        c = pal_count[slot];
        if (c < cmax) c = c + 64'd1;
        pal_count[slot] = c;
        r.hit = 1'b1;
      end else if (pal_used < DEPTH) begin
        slot = pal_used;
        pal_color[slot] = key;
        pal_count[slot] = 64'd1;
        pal_used = pal_used + 1;
        c = 64'd1;
      end else begin
        r.dropped_full = 1'b1;
        slot = 0;
      end
    end else begin
      if (found) begin
        r.hit = 1'b1;
        c = pal_count[slot];
      end
      r.any_hit = set_any | r.hit;
      set_any = w.last_of_set ? 1'b0 : r.any_hit;
    end
    r.entry_index     = slot[7:0];
    r.color_count     = c[23:0];
    r.distinct_colors = pal_used[8:0];
    return r;
  endfunction

  task automatic note_diff(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt_o++;
      if (err_cnt_o <= 10)
        $display("result %0d: %s expected %0h got %0h", n_checked, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      pal_used = 0;
      set_any  = 1'b0;
      pending_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10) $display("output word %0h with none outstanding", out_word_i);
        end else begin
          exp_w = pending_results.pop_front();
          note_diff("hit", 32'(exp_w.hit), 32'(out_word_i.hit));
          note_diff("entry_index", 32'(exp_w.entry_index), 32'(out_word_i.entry_index));
          note_diff("color_count", 32'(exp_w.color_count), 32'(out_word_i.color_count));
          note_diff("dropped_full", 32'(exp_w.dropped_full), 32'(out_word_i.dropped_full));
          note_diff("distinct_colors", 32'(exp_w.distinct_colors),
                    32'(out_word_i.distinct_colors));
          note_diff("any_hit", 32'(exp_w.any_hit), 32'(out_word_i.any_hit));
        end
        n_checked++;
      end
      if (in_valid_i && !in_stall_i) begin
        exp_w = palette_step(in_word_i);
        if (exp_w.hit) hits_o++;
        if (exp_w.dropped_full) drops_o++;
        pending_results.push_back(exp_w);
      end
      pending_o = pending_results.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dch_pkg::*;

  localparam int unsigned DEPTH    = 256;
  localparam int unsigned CNT_BITS = 24;
  localparam int          NumRand  = 2000;
  localparam int          PoolSize = 300;
  localparam int          Latency  = DEPTH + 2;

  bit        clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int err_cnt;
  int pending;
  int hits;
  int drops;

  int  sent     = 0;
  int  n_adds   = 0;
  int  n_query  = 0;
  int  n_sets   = 0;
  bit  quiet    = 1'b0;
  bit  hold_rx  = 1'b0;

  // pool of recurring colors; larger than the palette so it overflows
  bit [23:0] color_pool [PoolSize];

  always #10 clk = ~clk;

  distinct_color_histogram_unit #(
    .TABLE_DEPTH(DEPTH),
    .COUNT_BITS (CNT_BITS)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  dch_checker #(
    .DEPTH   (DEPTH),
    .CNT_BITS(CNT_BITS)
  ) u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_word_i  (in_word),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_word_i (out_word),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .hits_o     (hits),
    .drops_o    (drops)
  );

  function automatic in_word_t make_word(cmd_e cmd, bit [23:0] rgb, bit last);
    in_word_t w;
    w.command     = cmd;
    w.red         = rgb[23:16];
    w.green       = rgb[15:8];
    w.blue        = rgb[7:0];
    w.last_of_set = last;
    return w;
  endfunction

  function automatic bit [23:0] pick_color(int fresh_pct);
    bit [23:0] rgb;
    if ($urandom_range(99) < fresh_pct) rgb = 24'($urandom());
    else rgb = color_pool[$urandom_range(PoolSize - 1)];
    return rgb;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    if (!quiet && $urandom_range(99) < 24) begin
      gap = ($urandom_range(49) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (w.command == CMD_ADD) n_adds++;
    else n_query++;
    if (w.command == CMD_QUERY && w.last_of_set) n_sets++;
    quiet <= (sent >= 900 && sent < 1200);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, none in the quiet stretch
  always @(posedge clk) begin
    out_stall <= hold_rx || (!quiet && $urandom_range(99) < 24);
  end

  // long receiver hold-off while the sender keeps offering words
  initial begin
    wait (sent >= 500);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (1500) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    int len;
    int r;
    in_valid = 1'b0;
    in_word  = '0;
    rst_n    = 1'b0;
    color_pool[0] = 24'h000000;
    color_pool[1] = 24'hFFFFFF;
    for (int i = 2; i < PoolSize; i++) color_pool[i] = 24'($urandom());
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty palette, inserts, hits, query sets across adds
    send_word(make_word(CMD_QUERY, 24'h000000, 1'b1));
    send_word(make_word(CMD_ADD,   24'h000000, 1'b0));
    send_word(make_word(CMD_ADD,   24'hFFFFFF, 1'b1));
    send_word(make_word(CMD_ADD,   24'h000000, 1'b0));
    send_word(make_word(CMD_QUERY, 24'hFFFFFF, 1'b0));
    send_word(make_word(CMD_QUERY, 24'h123456, 1'b0));
    send_word(make_word(CMD_ADD,   24'h5A5A5A, 1'b1)); // add must not clear any-hit
    send_word(make_word(CMD_QUERY, 24'hABCDEF, 1'b1));
    send_word(make_word(CMD_QUERY, 24'hABCDEF, 1'b1));
    send_word(make_word(CMD_QUERY, 24'h000000, 1'b1));
    send_word(make_word(CMD_ADD,   24'hFF0000, 1'b0));
    send_word(make_word(CMD_ADD,   24'h00FF00, 1'b0));
    send_word(make_word(CMD_ADD,   24'h0000FF, 1'b0));
    send_word(make_word(CMD_ADD,   24'hFFFFFE, 1'b0));
    send_word(make_word(CMD_ADD,   24'hFFFFFF, 1'b0));
    send_word(make_word(CMD_QUERY, 24'h0000FF, 1'b0));
    send_word(make_word(CMD_QUERY, 24'h00FF00, 1'b1));
    send_word(make_word(CMD_QUERY, 24'h000001, 1'b0));
    send_word(make_word(CMD_QUERY, 24'h800000, 1'b1));
    send_word(make_word(CMD_ADD,   24'hA5C3E7, 1'b1));
    drain();

    // random: mostly closed query sets and add bursts, some noise.
    // Palette overflows partway through; count saturation is out of reach.
    while (sent < NumRand + 20) begin
      r = $urandom_range(99);
      if (r < 45) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
          send_word(make_word(CMD_QUERY, pick_color(30), k == len - 1));
      end else if (r < 90) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          send_word(make_word(CMD_ADD, pick_color(10), 1'($urandom_range(1))));
      end else begin
        send_word(make_word(cmd_e'($urandom_range(1)), pick_color(50),
                            1'($urandom_range(1))));
      end
    end
    drain();
    repeat (Latency + 20) @(posedge clk);

    $display("%0d words: %0d adds, %0d queries closing %0d sets", sent, n_adds, n_query,
             n_sets);
    $display("%0d hits predicted, %0d colors dropped on a full palette", hits, drops);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(64'd100_000_000);
    $display("tb: errors");
    $finish;
  end

endmodule
